// ----- rtl/csl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types, widths and character tables of the C subset lexer.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int POS_BITS    = 32;
  localparam int OUT_POS_W   = 32;
  localparam int LINE_W      = 24;
  localparam int COL_W       = 16;
  localparam int VAL_W       = 31;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [COL_W-1:0]  COL_MAX  = '1;
  localparam logic [VAL_W-1:0]  NUM_MAX  = '1;

  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_UNDER = 8'h5f;

  typedef enum logic [2:0] {
    SM_IDLE   = 3'd0,
    SM_IDENT  = 3'd1,
    SM_NUMBER = 3'd2,
    SM_SLASH  = 3'd3,
    SM_LINE   = 3'd4,
    SM_BLOCK  = 3'd5,
    SM_BSTAR  = 3'd6
  } scan_mode_e;

  typedef enum logic [4:0] {
    TK_END     = 5'd0,
    TK_INT     = 5'd1,
    TK_VOID    = 5'd2,
    TK_RETURN  = 5'd3,
    TK_IDENT   = 5'd4,
    TK_NUMBER  = 5'd5,
    TK_PLUS    = 5'd6,
    TK_MINUS   = 5'd7,
    TK_STAR    = 5'd8,
    TK_SLASH   = 5'd9,
    TK_LPAREN  = 5'd10,
    TK_RPAREN  = 5'd11,
    TK_LBRACE  = 5'd12,
    TK_RBRACE  = 5'd13,
    TK_SEMI    = 5'd14,
    TK_COMMA   = 5'd15,
    TK_ASSIGN  = 5'd16,
    TK_UNKNOWN = 5'd17
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e             kind;
    logic [OUT_POS_W-1:0]  start_pos;
    logic [OUT_POS_W-1:0]  end_pos;
    logic [LINE_W-1:0]     start_line;
    logic [COL_W-1:0]      start_column;
    logic [LINE_W-1:0]     end_line;
    logic [COL_W-1:0]      end_column;
    logic [VAL_W-1:0]      number_value;
    logic                  number_overflow;
    logic [7:0]            unknown_char;
  } tok_t;

  typedef struct packed {
    tok_t tok0;
    tok_t tok1;
    logic has1;
  } tok_pair_t;

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (k)
      2'd0: begin
        unique case (i)
          3'd0:    ch = "i";
          3'd1:    ch = "n";
          3'd2:    ch = "t";
          default: ch = 8'h00;
        endcase
      end
      2'd1: begin
        unique case (i)
          3'd0:    ch = "v";
          3'd1:    ch = "o";
          3'd2:    ch = "i";
          3'd3:    ch = "d";
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        unique case (i)
          3'd0:    ch = "r";
          3'd1:    ch = "e";
          3'd2:    ch = "t";
          3'd3:    ch = "u";
          3'd4:    ch = "r";
          3'd5:    ch = "n";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] len;
    unique case (k)
      2'd0:    len = 3'd3;
      2'd1:    len = 3'd4;
      2'd2:    len = 3'd6;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // Drop every keyword candidate that the next identifier byte rules out.
  function automatic logic [2:0] kw_feed(input logic [2:0] match, input logic [2:0] len,
                                         input logic [7:0] c);
    logic [2:0] m;
    m = match;
    for (int k = 0; k < 3; k++) begin
      if (match[k] && ((len >= kw_len(2'(k))) || (kw_char(2'(k), len) != c))) begin
        m[k] = 1'b0;
      end
    end
    return m;
  endfunction

  function automatic tok_kind_e op_kind(input logic [7:0] c);
    tok_kind_e kind;
    unique case (c)
      "+":     kind = TK_PLUS;
      "-":     kind = TK_MINUS;
      "*":     kind = TK_STAR;
      "(":     kind = TK_LPAREN;
      ")":     kind = TK_RPAREN;
      "{":     kind = TK_LBRACE;
      "}":     kind = TK_RBRACE;
      ";":     kind = TK_SEMI;
      ",":     kind = TK_COMMA;
      "=":     kind = TK_ASSIGN;
      default: kind = TK_UNKNOWN;
    endcase
    return kind;
  endfunction

endpackage

// ----- rtl/csl_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_if
// Valid/ready channels for source bytes and for tokens.
// ----------------------------------------------------------------------------
interface csl_byte_if import csl_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface csl_tok_if import csl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [4:0]           token_kind;
  logic [OUT_POS_W-1:0] start_pos;
  logic [OUT_POS_W-1:0] end_pos;
  logic [LINE_W-1:0]    start_line;
  logic [COL_W-1:0]     start_column;
  logic [LINE_W-1:0]    end_line;
  logic [COL_W-1:0]     end_column;
  logic [VAL_W-1:0]     number_value;
  logic                 number_overflow;
  logic [7:0]           unknown_char;
  logic                 last_of_run;

  modport source (output valid, token_kind, start_pos, end_pos, start_line, start_column,
                  end_line, end_column, number_value, number_overflow, unknown_char,
                  last_of_run, input ready);
  modport sink   (input valid, token_kind, start_pos, end_pos, start_line, start_column,
                  end_line, end_column, number_value, number_overflow, unknown_char,
                  last_of_run, output ready);
endinterface

// ----- rtl/csl_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_front
// Scanner: classifies each byte, tracks position, emits up to two tokens.
// ----------------------------------------------------------------------------
module csl_front import csl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  csl_byte_if.sink   text_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output tok_pair_t  push_data_o
);

  scan_mode_e          mode_q, mode_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [LINE_W-1:0]   line_q, line_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [POS_BITS-1:0] spos_q, spos_d;
  logic [LINE_W-1:0]   sline_q, sline_d;
  logic [COL_W-1:0]    scol_q, scol_d;
  logic [VAL_W-1:0]    acc_q, acc_d;
  logic                ovf_q, ovf_d;
  logic [2:0]          kw_q, kw_d;
  logic [2:0]          len_q, len_d;

  logic       accept, eot;
  logic [7:0] c;
  logic       is_space, is_alpha, is_digit, is_word, id_start;
  logic       restart, pending, flush_v, single_v;
  logic [VAL_W+3:0]    acc_wide;
  logic [POS_BITS-1:0] pos_m1;
  tok_t       flush_tok, single_tok;

  assign text_i.ready = push_ready_i;
  assign accept   = text_i.valid && text_i.ready;
  assign eot      = text_i.end_of_text;
  assign c        = text_i.text_byte;

  assign is_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  assign is_alpha = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  assign is_digit = (c >= "0") && (c <= "9");
  assign id_start = is_alpha || (c == CH_UNDER);
  assign is_word  = id_start || is_digit;

  assign acc_wide = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (VAL_W+4)'(c[3:0]);
  assign pos_m1   = pos_q - POS_BITS'(1);

  always_comb begin
    unique case (mode_q)
      SM_IDENT:  restart = !is_word;
      SM_NUMBER: restart = !is_digit;
      SM_SLASH:  restart = (c != CH_SLASH) && (c != CH_STAR);
      SM_LINE, SM_BLOCK, SM_BSTAR: restart = 1'b0;
      default:   restart = 1'b1;
    endcase
  end

  assign pending  = (mode_q == SM_IDENT) || (mode_q == SM_NUMBER) || (mode_q == SM_SLASH);
  assign flush_v  = accept && pending && (eot || restart);
  assign single_v = accept && (eot || (restart && !is_space && !id_start && !is_digit
                                       && (c != CH_SLASH)));

  // Next state
  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    line_d  = line_q;
    col_d   = col_q;
    spos_d  = spos_q;
    sline_d = sline_q;
    scol_d  = scol_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    kw_d    = kw_q;
    len_d   = len_q;
    if (accept) begin
      if (eot) begin
        mode_d  = SM_IDLE;
        pos_d   = '0;
        line_d  = LINE_W'(1);
        col_d   = COL_W'(1);
        spos_d  = '0;
        sline_d = LINE_W'(1);
        scol_d  = COL_W'(1);
        acc_d   = '0;
        ovf_d   = 1'b0;
        kw_d    = 3'b111;
        len_d   = 3'd0;
      end else begin
        pos_d = pos_q + POS_BITS'(1);
        if (c == CH_NL) begin
          if (line_q != LINE_MAX) line_d = line_q + LINE_W'(1);
          col_d = COL_W'(1);
        end else if (col_q != COL_MAX) begin
          col_d = col_q + COL_W'(1);
        end
        if (restart) begin
          mode_d = SM_IDLE;
          priority if (id_start) begin
            spos_d  = pos_q;
            sline_d = line_q;
            scol_d  = col_q;
            kw_d    = kw_feed(3'b111, 3'd0, c);
            len_d   = 3'd1;
            mode_d  = SM_IDENT;
          end else if (is_digit) begin
            spos_d  = pos_q;
            sline_d = line_q;
            scol_d  = col_q;
            acc_d   = VAL_W'(c[3:0]);
            ovf_d   = 1'b0;
            mode_d  = SM_NUMBER;
          end else if (c == CH_SLASH) begin
            spos_d  = pos_q;
            sline_d = line_q;
            scol_d  = col_q;
            mode_d  = SM_SLASH;
          end
        end else begin
          unique case (mode_q)
            SM_IDENT: begin
              kw_d = kw_feed(kw_q, len_q, c);
              if (len_q != 3'd7) len_d = len_q + 3'd1;
            end
            SM_NUMBER: begin
              if (acc_wide > (VAL_W+4)'(NUM_MAX)) begin
                acc_d = NUM_MAX;
                ovf_d = 1'b1;
              end else begin
                acc_d = acc_wide[VAL_W-1:0];
              end
            end
            SM_SLASH: mode_d = (c == CH_SLASH) ? SM_LINE : SM_BLOCK;
            SM_LINE:  if (c == CH_NL) mode_d = SM_IDLE;
            SM_BLOCK: if (c == CH_STAR) mode_d = SM_BSTAR;
            SM_BSTAR: begin
              if (c == CH_SLASH) mode_d = SM_IDLE;
              else if (c != CH_STAR) mode_d = SM_BLOCK;
            end
            default:  mode_d = SM_IDLE;
          endcase
        end
      end
    end
  end

  // Outputs
  always_comb begin
    flush_tok                 = '0;
    flush_tok.start_pos       = OUT_POS_W'(spos_q);
    flush_tok.start_line      = sline_q;
    flush_tok.start_column    = scol_q;
    flush_tok.end_pos         = OUT_POS_W'(pos_m1);
    flush_tok.end_line        = line_q;
    flush_tok.end_column      = col_q - COL_W'(1);
    unique case (mode_q)
      SM_IDENT: begin
        priority if (kw_q[0] && (len_q == kw_len(2'd0))) flush_tok.kind = TK_INT;
        else if (kw_q[1] && (len_q == kw_len(2'd1)))     flush_tok.kind = TK_VOID;
        else if (kw_q[2] && (len_q == kw_len(2'd2)))     flush_tok.kind = TK_RETURN;
        else                                             flush_tok.kind = TK_IDENT;
      end
      SM_NUMBER: begin
        flush_tok.kind            = TK_NUMBER;
        flush_tok.number_value    = acc_q;
        flush_tok.number_overflow = ovf_q;
      end
      default: begin
        flush_tok.kind       = TK_SLASH;
        flush_tok.end_pos    = OUT_POS_W'(spos_q);
        flush_tok.end_line   = sline_q;
        flush_tok.end_column = scol_q;
      end
    endcase

    single_tok              = '0;
    single_tok.start_pos    = OUT_POS_W'(pos_q);
    single_tok.start_line   = line_q;
    single_tok.start_column = col_q;
    single_tok.end_pos      = OUT_POS_W'(pos_q);
    single_tok.end_line     = line_q;
    single_tok.end_column   = col_q;
    if (eot) begin
      single_tok.kind = TK_END;
    end else begin
      single_tok.kind = op_kind(c);
      if (single_tok.kind == TK_UNKNOWN) single_tok.unknown_char = c;
    end

    push_valid_o = flush_v || single_v;
    if (flush_v) begin
      push_data_o.tok0 = flush_tok;
      push_data_o.tok1 = single_tok;
      push_data_o.has1 = single_v;
    end else begin
      push_data_o.tok0 = single_tok;
      push_data_o.tok1 = single_tok;
      push_data_o.has1 = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= SM_IDLE;
      pos_q   <= '0;
      line_q  <= LINE_W'(1);
      col_q   <= COL_W'(1);
      spos_q  <= '0;
      sline_q <= LINE_W'(1);
      scol_q  <= COL_W'(1);
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      kw_q    <= 3'b111;
      len_q   <= 3'd0;
    end else begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
      col_q   <= col_d;
      spos_q  <= spos_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      kw_q    <= kw_d;
      len_q   <= len_d;
    end
  end

`ifndef SYNTHESIS
  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && eot) |=> (mode_q == SM_IDLE && pos_q == '0 && line_q == LINE_W'(1)))
    else $error("end of text did not clear scanner state");
  a_col_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q != '0)
    else $error("column counter reached zero");
`endif

endmodule

// ----- rtl/csl_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_queue
// Short FIFO of token pairs between scanner and output stage.
// ----------------------------------------------------------------------------
module csl_queue import csl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  tok_pair_t push_data_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output tok_pair_t pop_data_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  tok_pair_t          mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) wr_d = (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
    if (pop)  rd_d = (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
    if (push && !pop) cnt_d = cnt_q + CNT_W'(1);
    else if (pop && !push) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("queue count did not follow a lone push");
`endif

endmodule

// ----- rtl/csl_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_back
// Output stage: holds one token pair and sends its tokens one beat each.
// ----------------------------------------------------------------------------
module csl_back import csl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pop_valid_i,
  output logic      pop_ready_o,
  input  tok_pair_t pop_data_i,
  csl_tok_if.source token_o
);

  logic      bvalid_q, bvalid_d;
  logic      idx_q, idx_d;
  tok_pair_t pair_q, pair_d;
  logic      fire, last, load;
  tok_t      cur;

  assign fire        = bvalid_q && token_o.ready;
  assign last        = idx_q || !pair_q.has1;
  assign load        = !bvalid_q || (fire && last);
  assign pop_ready_o = load;
  assign cur         = idx_q ? pair_q.tok1 : pair_q.tok0;

  always_comb begin
    bvalid_d = bvalid_q;
    idx_d    = idx_q;
    pair_d   = pair_q;
    if (load) begin
      bvalid_d = pop_valid_i;
      idx_d    = 1'b0;
      if (pop_valid_i) pair_d = pop_data_i;
    end else if (fire) begin
      idx_d = 1'b1;
    end
  end

  assign token_o.valid           = bvalid_q;
  assign token_o.token_kind      = cur.kind;
  assign token_o.start_pos       = cur.start_pos;
  assign token_o.end_pos         = cur.end_pos;
  assign token_o.start_line      = cur.start_line;
  assign token_o.start_column    = cur.start_column;
  assign token_o.end_line        = cur.end_line;
  assign token_o.end_column      = cur.end_column;
  assign token_o.number_value    = cur.number_value;
  assign token_o.number_overflow = cur.number_overflow;
  assign token_o.unknown_char    = cur.unknown_char;
  assign token_o.last_of_run     = last;

  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= 1'b0;
      idx_q    <= 1'b0;
    end else begin
      bvalid_q <= bvalid_d;
      idx_q    <= idx_d;
    end
  end

`ifndef SYNTHESIS
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !last) |=> (bvalid_q && idx_q))
    else $error("second token of a pair was lost");
  a_single_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bvalid_q && !pair_q.has1) |-> !idx_q)
    else $error("empty second slot selected");
`endif

endmodule

// ----- rtl/c_subset_lexer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_subset_lexer_core
// Streaming lexer for a small C subset: bytes in, tokens with spans out.
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  text_i    in   one source byte, or end of text
//  token_o   out  one token with span, value and last-of-run flag
//
//  One byte is accepted per cycle while the queue has room; each token is
//  registered in the queue and then in the output stage before it leaves.
//  A byte that closes a pending token and starts an operator (or end of
//  text after a pending token) yields two beats, which the two-entry queue
//  absorbs. Reset clears position to zero and line and column to one.
//  text_i stalls only when the queue is full.
// ----------------------------------------------------------------------------
module c_subset_lexer_core import csl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  csl_byte_if.sink  text_i,
  csl_tok_if.source token_o
);

  logic      push_valid, push_ready, pop_valid, pop_ready;
  tok_pair_t push_data, pop_data;

  csl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_i       (text_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  csl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  csl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .token_o     (token_o)
  );

endmodule
